// ===== src/v3ncd_pkg.sv =====
// ----------------------------------------------------------------------------
// v3ncd_pkg
// Shared types and constants of the fixed-point vector unit (normalize,
// cross product, dot product).
// ----------------------------------------------------------------------------
package v3ncd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // One result bit per square-root stage for a 64-bit radicand.
  localparam int SQRT_STAGES   = 32;

  typedef enum logic [1:0] {
    FUNC_NORM  = 2'd0,
    FUNC_CROSS = 2'd1,
    FUNC_DOT   = 2'd2
  } func_e;

  typedef struct packed {
    func_e              func;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
  } item_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic               zero_length;
    logic               saturated;
  } result_t;

  // Cross or dot result, finished early and carried along the pipeline.
  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic               saturated;
  } part_t;

  // Context that travels beside the square-root stages.
  typedef struct packed {
    func_e              func;
    logic               zl;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    part_t              part;
  } sq_side_t;

  // Context that travels beside the divider stages.
  typedef struct packed {
    func_e func;
    logic  zl;
    part_t part;
  } dv_side_t;

endpackage

// ===== src/v3ncd_mul.sv =====
// ----------------------------------------------------------------------------
// v3ncd_mul
// First pipeline stage: selects operands by operation and forms six
// registered 32x32 signed products.
// ----------------------------------------------------------------------------
module v3ncd_mul
  import v3ncd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  item_t              item_i,
  output logic               valid_o,
  output func_e              func_o,
  output logic signed [31:0] ax_o,
  output logic signed [31:0] ay_o,
  output logic signed [31:0] az_o,
  output logic signed [63:0] prod_o [6]
);

  logic signed [31:0] op_a [6];
  logic signed [31:0] op_b [6];
  logic signed [63:0] prod_d [6];
  logic signed [63:0] prod_q [6];
  logic               valid_q;
  func_e              func_q;
  logic signed [31:0] ax_q, ay_q, az_q;

  always_comb begin
    op_a = '{default: '0};
    op_b = '{default: '0};
    unique case (item_i.func)
      FUNC_NORM: begin
        op_a[0] = item_i.ax; op_b[0] = item_i.ax;
        op_a[1] = item_i.ay; op_b[1] = item_i.ay;
        op_a[2] = item_i.az; op_b[2] = item_i.az;
      end
      FUNC_CROSS: begin
        op_a[0] = item_i.ay; op_b[0] = item_i.bz;
        op_a[1] = item_i.az; op_b[1] = item_i.by;
        op_a[2] = item_i.az; op_b[2] = item_i.bx;
        op_a[3] = item_i.ax; op_b[3] = item_i.bz;
        op_a[4] = item_i.ax; op_b[4] = item_i.by;
        op_a[5] = item_i.ay; op_b[5] = item_i.bx;
      end
      FUNC_DOT: begin
        op_a[0] = item_i.ax; op_b[0] = item_i.bx;
        op_a[1] = item_i.ay; op_b[1] = item_i.by;
        op_a[2] = item_i.az; op_b[2] = item_i.bz;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < 6; i++) begin : g_mul
    assign prod_d[i] = 64'(op_a[i]) * 64'(op_b[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    func_q <= item_i.func;
    ax_q   <= item_i.ax;
    ay_q   <= item_i.ay;
    az_q   <= item_i.az;
  end

  assign valid_o = valid_q;
  assign func_o  = func_q;
  assign ax_o    = ax_q;
  assign ay_o    = ay_q;
  assign az_o    = az_q;
  assign prod_o  = prod_q;

endmodule

// ===== src/v3ncd_comb.sv =====
// ----------------------------------------------------------------------------
// v3ncd_comb
// Two stages: exact sums of products, then floor shift and clamp of the
// cross and dot results; also the sum of squares for normalize.
// ----------------------------------------------------------------------------
module v3ncd_comb
  import v3ncd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  func_e              func_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  logic signed [31:0] az_i,
  input  logic signed [63:0] prod_i [6],
  output logic               valid_o,
  output logic [63:0]        sq_o,
  output sq_side_t           side_o
);

  localparam logic signed [65:0] S32Max = 66'sd2147483647;
  localparam logic signed [65:0] S32Min = -66'sd2147483648;

  logic signed [65:0] sum_d [3];
  logic signed [65:0] sum_q [3];
  logic [63:0]        sq_d, sq_a_q, sq_b_q;
  logic               valid_a_q, valid_b_q;
  func_e              func_a_q;
  logic signed [31:0] ax_a_q, ay_a_q, az_a_q;
  logic signed [31:0] clamp [3];
  logic [2:0]         sat;
  sq_side_t           side_d, side_q;

  always_comb begin
    sum_d = '{default: '0};
    unique case (func_i)
      FUNC_CROSS: begin
        sum_d[0] = 66'(prod_i[0]) - 66'(prod_i[1]);
        sum_d[1] = 66'(prod_i[2]) - 66'(prod_i[3]);
        sum_d[2] = 66'(prod_i[4]) - 66'(prod_i[5]);
      end
      FUNC_DOT: begin
        sum_d[0] = 66'(prod_i[0]) + 66'(prod_i[1]) + 66'(prod_i[2]);
      end
      default: begin
      end
    endcase
  end

  // Squares are never negative and three of them stay below 2^64.
  assign sq_d = $unsigned(prod_i[0]) + $unsigned(prod_i[1]) + $unsigned(prod_i[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    sq_a_q   <= sq_d;
    func_a_q <= func_i;
    ax_a_q   <= ax_i;
    ay_a_q   <= ay_i;
    az_a_q   <= az_i;
  end

  // An arithmetic shift of the exact sum is the floor of the quotient.
  for (genvar i = 0; i < 3; i++) begin : g_clamp
    logic signed [65:0] shifted;
    assign shifted = sum_q[i] >>> FRAC_BITS;
    always_comb begin
      sat[i]   = 1'b0;
      clamp[i] = shifted[31:0];
      if (shifted > S32Max) begin
        sat[i]   = 1'b1;
        clamp[i] = S32Max[31:0];
      end else if (shifted < S32Min) begin
        sat[i]   = 1'b1;
        clamp[i] = S32Min[31:0];
      end
    end
  end

  always_comb begin
    side_d.func           = func_a_q;
    side_d.zl             = (func_a_q == FUNC_NORM) && (sq_a_q == '0);
    side_d.ax             = ax_a_q;
    side_d.ay             = ay_a_q;
    side_d.az             = az_a_q;
    side_d.part.rx        = clamp[0];
    side_d.part.ry        = clamp[1];
    side_d.part.rz        = clamp[2];
    side_d.part.saturated = |sat;
  end

  always_ff @(posedge clk_i) begin
    sq_b_q <= sq_a_q;
    side_q <= side_d;
  end

  assign valid_o = valid_b_q;
  assign sq_o    = sq_b_q;
  assign side_o  = side_q;

endmodule

// ===== src/v3ncd_isqrt.sv =====
// ----------------------------------------------------------------------------
// v3ncd_isqrt
// Pipelined integer square root of a 64-bit value, one result bit per
// stage, with the item context carried beside it.
// ----------------------------------------------------------------------------
module v3ncd_isqrt
  import v3ncd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] sq_i,
  input  sq_side_t    side_i,
  output logic        valid_o,
  output logic [31:0] len_o,
  output sq_side_t    side_o
);

  logic        valid_q [SQRT_STAGES];
  logic [63:0] rem_q   [SQRT_STAGES];
  logic [63:0] root_q  [SQRT_STAGES];
  sq_side_t    side_q  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [63:0] BitK = 64'd1 << (62 - 2 * k);
    logic        v_in;
    logic [63:0] rem_in, root_in;
    sq_side_t    side_in;
    logic [64:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = sq_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {1'b0, root_in} + {1'b0, BitK};
    assign ge    = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      if (ge) begin
        rem_q[k]  <= rem_in - trial[63:0];
        root_q[k] <= (root_in >> 1) + BitK;
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= root_in >> 1;
      end
    end
  end

  assign valid_o = valid_q[SQRT_STAGES-1];
  assign len_o   = root_q[SQRT_STAGES-1][31:0];
  assign side_o  = side_q[SQRT_STAGES-1];

endmodule

// ===== src/v3ncd_div.sv =====
// ----------------------------------------------------------------------------
// v3ncd_div
// Three-lane pipelined restoring divider: each component magnitude, scaled
// by the fraction bits, over the vector length, one quotient bit per stage.
// ----------------------------------------------------------------------------
module v3ncd_div
  import v3ncd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [31:0]          len_i,
  input  sq_side_t             side_i,
  output logic                 valid_o,
  output logic [FRAC_BITS:0]   quo_o [3],
  output logic [2:0]           neg_o,
  output dv_side_t             side_o
);

  // The quotient never exceeds 2^FRAC_BITS, so FRAC_BITS+1 bits suffice.
  localparam int NQ = FRAC_BITS + 1;
  localparam int RW = FRAC_BITS + 33;

  logic               valid_q [NQ];
  logic [RW-1:0]      rem_q   [NQ][3];
  logic [FRAC_BITS:0] quo_q   [NQ][3];
  logic [31:0]        len_q   [NQ];
  logic [2:0]         neg_q   [NQ];
  dv_side_t           side_q  [NQ];

  logic signed [31:0] comp [3];
  logic [31:0]        mag  [3];
  logic [2:0]         neg_in0;
  dv_side_t           side_in0;

  assign comp[0] = side_i.ax;
  assign comp[1] = side_i.ay;
  assign comp[2] = side_i.az;

  for (genvar j = 0; j < 3; j++) begin : g_mag
    assign mag[j]     = comp[j][31] ? 32'(-comp[j]) : 32'(comp[j]);
    assign neg_in0[j] = comp[j][31];
  end

  assign side_in0.func = side_i.func;
  assign side_in0.zl   = side_i.zl;
  assign side_in0.part = side_i.part;

  for (genvar i = 0; i < NQ; i++) begin : g_stage
    localparam int B = FRAC_BITS - i;
    localparam logic [FRAC_BITS:0] QBit = {{FRAC_BITS{1'b0}}, 1'b1} << B;
    logic          v_in;
    logic [31:0]   len_in;
    logic [2:0]    neg_in;
    dv_side_t      side_in;
    logic [RW-1:0] dsh;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign len_in  = len_i;
      assign neg_in  = neg_in0;
      assign side_in = side_in0;
    end else begin : g_next
      assign v_in    = valid_q[i-1];
      assign len_in  = len_q[i-1];
      assign neg_in  = neg_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign dsh = RW'(len_in) << B;

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [RW-1:0]      rem_in;
      logic [FRAC_BITS:0] quo_in;
      logic               ge;

      if (i == 0) begin : g_first
        assign rem_in = RW'(mag[j]) << FRAC_BITS;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[i-1][j];
        assign quo_in = quo_q[i-1][j];
      end

      assign ge = rem_in >= dsh;

      always_ff @(posedge clk_i) begin
        if (ge) begin
          rem_q[i][j] <= rem_in - dsh;
          quo_q[i][j] <= quo_in | QBit;
        end else begin
          rem_q[i][j] <= rem_in;
          quo_q[i][j] <= quo_in;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      len_q[i]  <= len_in;
      neg_q[i]  <= neg_in;
      side_q[i] <= side_in;
    end
  end

  assign valid_o = valid_q[NQ-1];
  assign quo_o   = quo_q[NQ-1];
  assign neg_o   = neg_q[NQ-1];
  assign side_o  = side_q[NQ-1];

endmodule

// ===== src/vec3_normalize_cross_dot.sv =====
// ----------------------------------------------------------------------------
// vec3_normalize_cross_dot
// Fixed-point three-component vector unit: normalize, cross and dot.
// ----------------------------------------------------------------------------
// Usage: drive item_i and raise start for one cycle per item; the item is
// transferred at the rising edge where start is high and busy is low. busy
// is always low, so a new item may be transferred in every cycle.
// Every item yields one result on result_o, marked by done_o for exactly one
// cycle; the receiver cannot hold results off and must take each transfer.
// The path from the transfer edge to done_o runs through one product
// stage, two sum and clamp stages, 32 square-root stages, FRAC_BITS + 1
// divider stages and an output register. All operations take the same
// path, so results leave in the order the items came in; throughput is
// one item per cycle. Reset clears every valid bit, dropping items in
// flight; there is no state beyond the pipeline and no warm-up after
// reset.
// ----------------------------------------------------------------------------
module vec3_normalize_cross_dot
  import v3ncd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  localparam int LAT = 5 + SQRT_STAGES + FRAC_BITS;
  localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

  logic               mul_valid;
  func_e              mul_func;
  logic signed [31:0] mul_ax, mul_ay, mul_az;
  logic signed [63:0] mul_prod [6];

  logic               cmb_valid;
  logic [63:0]        cmb_sq;
  sq_side_t           cmb_side;

  logic               sqr_valid;
  logic [31:0]        sqr_len;
  sq_side_t           sqr_side;

  logic               div_valid;
  logic [FRAC_BITS:0] div_quo [3];
  logic [2:0]         div_neg;
  dv_side_t           div_side;

  logic signed [31:0] norm [3];
  result_t            result_d, result_q;
  logic               done_q;

  assign busy = 1'b0;

  v3ncd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (item_i),
    .valid_o (mul_valid),
    .func_o  (mul_func),
    .ax_o    (mul_ax),
    .ay_o    (mul_ay),
    .az_o    (mul_az),
    .prod_o  (mul_prod)
  );

  v3ncd_comb #(.FRAC_BITS(FRAC_BITS)) u_comb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .func_i  (mul_func),
    .ax_i    (mul_ax),
    .ay_i    (mul_ay),
    .az_i    (mul_az),
    .prod_i  (mul_prod),
    .valid_o (cmb_valid),
    .sq_o    (cmb_sq),
    .side_o  (cmb_side)
  );

  v3ncd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmb_valid),
    .sq_i    (cmb_sq),
    .side_i  (cmb_side),
    .valid_o (sqr_valid),
    .len_o   (sqr_len),
    .side_o  (sqr_side)
  );

  v3ncd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sqr_valid),
    .len_i   (sqr_len),
    .side_i  (sqr_side),
    .valid_o (div_valid),
    .quo_o   (div_quo),
    .neg_o   (div_neg),
    .side_o  (div_side)
  );

  for (genvar j = 0; j < 3; j++) begin : g_sign
    assign norm[j] = div_neg[j] ? -32'(div_quo[j]) : 32'(div_quo[j]);
  end

  always_comb begin
    result_d = '0;
    unique case (div_side.func)
      FUNC_NORM: begin
        // A zero vector has no direction; the divider output is meaningless.
        if (div_side.zl) begin
          result_d.zero_length = 1'b1;
        end else begin
          result_d.rx = norm[0];
          result_d.ry = norm[1];
          result_d.rz = norm[2];
        end
      end
      FUNC_CROSS, FUNC_DOT: begin
        result_d.rx        = div_side.part.rx;
        result_d.ry        = div_side.part.ry;
        result_d.rz        = div_side.part.rz;
        result_d.saturated = div_side.part.saturated;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result without a matching item transfer");

  a_zero_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.zero_length |->
      $past(item_i.ax, LAT) == 0 && $past(item_i.ay, LAT) == 0 &&
      $past(item_i.az, LAT) == 0)
    else $error("zero length flagged for a nonzero vector");

  a_sat_only_cross_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.saturated |->
      $past(item_i.func, LAT) == FUNC_CROSS || $past(item_i.func, LAT) == FUNC_DOT)
    else $error("saturation flagged for an operation that cannot clamp");

  a_norm_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(item_i.func, LAT) == FUNC_NORM |->
      result_o.rx <= One && result_o.rx >= -One &&
      result_o.ry <= One && result_o.ry >= -One &&
      result_o.rz <= One && result_o.rz >= -One)
    else $error("normalized component exceeds unit magnitude");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-point vector unit. A driver sends
// normalize, cross and dot items from a queue with random gaps; a monitor
// compares each result transfer with a prediction computed at transfer time.
// ----------------------------------------------------------------------------
module tb;
  import v3ncd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 37 + FB;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    done_o;
  result_t result_o;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      mismatches = 0;
  int      idle_left = 0;
  bit      quiet_tail = 0;

  vec3_normalize_cross_dot #(.FRAC_BITS(FB)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic longint clamp_s32(longint v, ref logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] root;
    logic [63:0] bit_v;
    root = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > s) bit_v >>= 2;
    while (bit_v != 0) begin
      if (s >= root + bit_v) begin
        s -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] unit_comp(longint a, logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (a < 0) ? -a : a;
    q = (mag << FB) / len;
    return (a < 0) ? -q[31:0] : q[31:0];
  endfunction

  // Products are exact in 128 bits; shifting the exact sum floors it.
  function automatic result_t vector_result(item_t it);
    result_t r;
    logic signed [127:0] ax, ay, az, bx, by, bz;
    logic [63:0] sq;
    logic [63:0] len;
    logic sat;
    r = '0;
    sat = 1'b0;
    ax = it.ax; ay = it.ay; az = it.az;
    bx = it.bx; by = it.by; bz = it.bz;
    case (it.func)
      FUNC_NORM: begin
        sq = 64'(ax * ax + ay * ay + az * az);
        if (sq == 0) begin
          r.zero_length = 1'b1;
        end else begin
          len = int_sqrt(sq);
          r.rx = unit_comp(it.ax, len);
          r.ry = unit_comp(it.ay, len);
          r.rz = unit_comp(it.az, len);
        end
      end
      FUNC_CROSS: begin
        r.rx = 32'(clamp_s32(64'((ay * bz - az * by) >>> FB), sat));
        r.ry = 32'(clamp_s32(64'((az * bx - ax * bz) >>> FB), sat));
        r.rz = 32'(clamp_s32(64'((ax * by - ay * bx) >>> FB), sat));
      end
      FUNC_DOT: begin
        r.rx = 32'(clamp_s32(64'((ax * bx + ay * by + az * bz) >>> FB), sat));
      end
      default: ;
    endcase
    r.saturated = sat;
    return r;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int sel;
    it.func = func_e'($urandom_range(0, 3) == 3 ? 2 : $urandom_range(0, 2));
    it.ax = $urandom; it.ay = $urandom; it.az = $urandom;
    it.bx = $urandom; it.by = $urandom; it.bz = $urandom;
    sel = $urandom_range(0, 3);
    // Most items use modest magnitudes so that results stay in range.
    if (sel != 0) begin
      it.ax = $signed(it.ax) >>> $urandom_range(0, 24);
      it.ay = $signed(it.ay) >>> $urandom_range(0, 24);
      it.az = $signed(it.az) >>> $urandom_range(0, 24);
      it.bx = $signed(it.bx) >>> $urandom_range(0, 24);
      it.by = $signed(it.by) >>> $urandom_range(0, 24);
      it.bz = $signed(it.bz) >>> $urandom_range(0, 24);
    end
    if ($urandom_range(0, 15) == 0) it.ay = 0;
    if ($urandom_range(0, 15) == 0) it.az = 0;
    return it;
  endfunction

  function automatic item_t make_item(func_e f, int a0, int a1, int a2,
                                      int b0, int b1, int b2);
    item_t it;
    it.func = f;
    it.ax = a0; it.ay = a1; it.az = a2;
    it.bx = b0; it.by = b1; it.bz = b2;
    return it;
  endfunction

  // Driver: random idle bursts between items, except in the quiet tail.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      item_i <= '0;
      idle_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(vector_result(item_i));
      end
      if (start && busy) begin
        // Hold the current item until it is transferred.
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        idle_left <= $urandom_range(0, 3);
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item_i <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $time, result_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (result_o.rx !== want.rx || result_o.ry !== want.ry ||
            result_o.rz !== want.rz || result_o.zero_length !== want.zero_length ||
            result_o.saturated !== want.saturated) begin
          $display("%0t: expected rx=%h ry=%h rz=%h zl=%b sat=%b", $time,
                   want.rx, want.ry, want.rz, want.zero_length, want.saturated);
          $display("%0t:   actual rx=%h ry=%h rz=%h zl=%b sat=%b", $time,
                   result_o.rx, result_o.ry, result_o.rz,
                   result_o.zero_length, result_o.saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_items.push_back(make_item(FUNC_NORM, 0, 0, 0, 5, 6, 7));
    pending_items.push_back(make_item(FUNC_NORM, 32'h10000, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NORM, 0, -32'h30000, 32'h40000, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NORM, 32'h80000000, 32'h80000000,
                                      32'h80000000, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NORM, 32'h7fffffff, 32'h7fffffff,
                                      32'h7fffffff, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NORM, 1, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NORM, -1, -1, -1, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_CROSS, 32'h10000, 0, 0, 0, 32'h10000, 0));
    pending_items.push_back(make_item(FUNC_CROSS, 32'h7fffffff, 32'h80000000,
                                      32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                      32'h80000000));
    pending_items.push_back(make_item(FUNC_CROSS, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h80000000));
    pending_items.push_back(make_item(FUNC_CROSS, -1, 1, -1, 1, -1, 3));
    pending_items.push_back(make_item(FUNC_DOT, 32'h10000, 32'h20000, 32'h30000,
                                      32'h40000, 32'h50000, 32'h60000));
    pending_items.push_back(make_item(FUNC_DOT, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h80000000));
    pending_items.push_back(make_item(FUNC_DOT, 32'h7fffffff, 32'h7fffffff,
                                      32'h7fffffff, 32'h80000000, 32'h80000000,
                                      32'h80000000));
    pending_items.push_back(make_item(FUNC_DOT, -1, -1, -1, 1, 1, 1));
    pending_items.push_back(make_item(FUNC_DOT, 0, 0, 0, -1, -1, -1));
    pending_items.push_back(make_item(func_e'(2'd3), -1, -1, -1, -1, -1, -1));
    repeat (1000) pending_items.push_back(random_item());

    wait (pending_items.size() < 150);
    quiet_tail = 1'b1;
    wait (pending_items.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== vec3_normalize_cross_dot.f =====
src/v3ncd_pkg.sv
src/v3ncd_mul.sv
src/v3ncd_comb.sv
src/v3ncd_isqrt.sv
src/v3ncd_div.sv
src/vec3_normalize_cross_dot.sv
tb/tb.sv
